// File: rtl/core/nta_pkg.sv
// Shared types and constants of the neighbor table with aging.
`timescale 1ns / 1ps

package nta_pkg;

  localparam int CAPACITY        = 16;
  localparam int IDX_W           = $clog2(CAPACITY);
  localparam int OUT_CNT_W       = 4;
  localparam logic [15:0] STALE_LIMIT_RST = 16'd64;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [0:0] {
    MODE_MSG   = 1'b0,
    MODE_PURGE = 1'b1
  } mode_e;

  typedef enum logic [0:0] {
    CMP_ID_EQ = 1'b0,
    CMP_AGE   = 1'b1
  } cmp_op_e;

  typedef struct packed {
    logic        mode;
    logic [15:0] sender_id;
    logic [7:0]  distance;
    logic [7:0]  sender_neighbor_count;
    logic [7:0]  sender_type;
    logic [7:0]  food_x;
    logic [7:0]  food_y;
    logic [7:0]  food_bearing;
    logic [7:0]  food_bearing_sign;
    logic [31:0] now_tick;
  } in_t;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] entry_count;
    logic [OUT_CNT_W-1:0] slot;
    logic                 matched;
    logic                 dropped;
    logic [OUT_CNT_W-1:0] removed_count;
  } out_t;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] tstamp;
    logic [7:0]  distance;
    logic [47:0] payload;
  } entry_t;

  typedef struct packed {
    logic   we;
    idx_t   waddr;
    entry_t wdata;
    logic   re;
    idx_t   raddr;
  } tbl_req_t;

  typedef struct packed {
    cmp_op_e     op;
    logic [31:0] a;
    logic [31:0] b;
  } cmp_req_t;

endpackage

// File: rtl/core/neighbor_table_with_aging.sv
// Neighbor table with aging: top level with the stale limit register.
//
// Usage: items enter on in_valid_i/in_ready_o as one nta_pkg::in_t word. A
// message item (mode 0) looks up sender_id among the counted entries and
// updates it, appends it, or writes the hidden last slot when the table is
// full. A purge item (mode 1) walks the entries from last to first and
// replaces each one older than the stale limit by the last entry.
// Every item gives exactly one result on out_valid_o/out_ready_i.
// The stale limit is written through cfg_valid_i/cfg_data_i, which is always
// ready; write it only while no item is in flight.
// Steps: one shared compare unit and one table read port are used for every
// step. Each visited entry has a table read and then a compare, and each
// purged entry also a read of the last entry and then a copy. A message item
// scans the entries up to the match (at most the count); a purge item visits
// every counted entry. One item is in work at a time, and the next transfer
// can be taken in the same cycle that the result appears.
// Reset clears the count to zero and the stale limit to 64; entry storage is
// not cleared. A stalled receiver holds the result register; the next item
// can be taken and worked, and waits in its done state until that register
// is free.
`timescale 1ns / 1ps

module neighbor_table_with_aging (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [15:0]   cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  nta_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output nta_pkg::out_t out_data_o
);

  logic [15:0]       stale_limit_q;
  nta_pkg::tbl_req_t tbl_req;
  nta_pkg::entry_t   tbl_rdata;
  nta_pkg::cmp_req_t cmp_req;
  logic              cmp_hit;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stale_limit_q <= nta_pkg::STALE_LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      stale_limit_q <= cfg_data_i;
    end
  end

  nta_table u_table (
    .clk_i   (clk_i),
    .req_i   (tbl_req),
    .rdata_o (tbl_rdata)
  );

  nta_cmp u_cmp (
    .req_i   (cmp_req),
    .limit_i (stale_limit_q),
    .hit_o   (cmp_hit)
  );

  nta_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .tbl_req_o   (tbl_req),
    .tbl_rdata_i (tbl_rdata),
    .cmp_req_o   (cmp_req),
    .cmp_hit_i   (cmp_hit)
  );

endmodule

// File: rtl/core/nta_table.sv
// Neighbor entry storage: one write port and one registered read port.
`timescale 1ns / 1ps

module nta_table (
  input  logic              clk_i,
  input  nta_pkg::tbl_req_t req_i,
  output nta_pkg::entry_t   rdata_o
);

  nta_pkg::entry_t mem_q [nta_pkg::CAPACITY];
  nta_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/nta_cmp.sv
// Shared compare unit: sender id equality or modular age against the stale limit.
`timescale 1ns / 1ps

module nta_cmp (
  input  nta_pkg::cmp_req_t req_i,
  input  logic [15:0]       limit_i,
  output logic              hit_o
);

  logic [31:0] diff;

  assign diff = req_i.a - req_i.b;

  always_comb begin
    case (req_i.op)
      nta_pkg::CMP_ID_EQ: hit_o = (req_i.a[15:0] == req_i.b[15:0]);
      nta_pkg::CMP_AGE:   hit_o = (diff > {16'd0, limit_i});
      default:            hit_o = 1'b0;
    endcase
  end

endmodule

// File: rtl/core/nta_seq.sv
// Sequencer that walks the table one entry at a time and holds the result register.
`timescale 1ns / 1ps

module nta_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  nta_pkg::in_t      in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output nta_pkg::out_t     out_data_o,
  output nta_pkg::tbl_req_t tbl_req_o,
  input  nta_pkg::entry_t   tbl_rdata_i,
  output nta_pkg::cmp_req_t cmp_req_o,
  input  logic              cmp_hit_i
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_RD      = 7'b0000010,
    S_CMP     = 7'b0000100,
    S_COPY_RD = 7'b0001000,
    S_COPY_WR = 7'b0010000,
    S_WR      = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_e;

  localparam nta_pkg::idx_t LAST_IDX = nta_pkg::IDX_W'(nta_pkg::CAPACITY - 1);

  state_e          state_q, state_d;
  nta_pkg::in_t    item_q, item_d;
  nta_pkg::idx_t   idx_q, idx_d;
  nta_pkg::idx_t   cnt_q, cnt_d;
  nta_pkg::idx_t   removed_q, removed_d;
  nta_pkg::idx_t   slot_q, slot_d;
  logic            matched_q, matched_d;
  logic            dropped_q, dropped_d;
  logic            out_valid_q, out_valid_d;
  nta_pkg::out_t   out_q, out_d;
  nta_pkg::idx_t   last_idx;
  nta_pkg::entry_t new_entry;
  logic            in_xfer;

  assign last_idx   = cnt_q - 1'b1;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    new_entry.id       = item_q.sender_id;
    new_entry.tstamp   = item_q.now_tick;
    new_entry.distance = item_q.distance;
    new_entry.payload  = {item_q.food_bearing_sign, item_q.food_bearing, item_q.food_y,
                          item_q.food_x, item_q.sender_type, item_q.sender_neighbor_count};
  end

  always_comb begin
    cmp_req_o.op = item_q.mode ? nta_pkg::CMP_AGE : nta_pkg::CMP_ID_EQ;
    cmp_req_o.a  = item_q.mode ? item_q.now_tick : {16'd0, item_q.sender_id};
    cmp_req_o.b  = item_q.mode ? tbl_rdata_i.tstamp : {16'd0, tbl_rdata_i.id};
  end

  always_comb begin
    tbl_req_o.we    = (state_q == S_WR) || (state_q == S_COPY_WR);
    tbl_req_o.waddr = idx_q;
    tbl_req_o.wdata = (state_q == S_WR) ? new_entry : tbl_rdata_i;
    tbl_req_o.re    = (state_q == S_RD) || (state_q == S_COPY_RD);
    tbl_req_o.raddr = (state_q == S_COPY_RD) ? last_idx : idx_q;
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    removed_d   = removed_q;
    slot_d      = slot_q;
    matched_d   = matched_q;
    dropped_d   = dropped_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          item_d    = in_data_i;
          removed_d = '0;
          slot_d    = '0;
          matched_d = 1'b0;
          dropped_d = 1'b0;
          if (in_data_i.mode == nta_pkg::MODE_MSG) begin
            idx_d = '0;
            if (cnt_q == '0) begin
              // Empty table: the new sender goes straight into the first entry.
              cnt_d   = nta_pkg::idx_t'(1);
              state_d = S_WR;
            end else begin
              state_d = S_RD;
            end
          end else begin
            idx_d   = last_idx;
            state_d = (cnt_q == '0) ? S_DONE : S_RD;
          end
        end
      end
      S_RD: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (item_q.mode == nta_pkg::MODE_MSG) begin
          if (cmp_hit_i) begin
            matched_d = 1'b1;
            state_d   = S_WR;
          end else begin
            idx_d = idx_q + 1'b1;
            if (idx_q == last_idx) begin
              // No match: append, or overwrite the hidden slot when full.
              // In both cases the slot is the current count.
              if (cnt_q == LAST_IDX) begin
                dropped_d = 1'b1;
              end else begin
                cnt_d = cnt_q + 1'b1;
              end
              state_d = S_WR;
            end else begin
              state_d = S_RD;
            end
          end
        end else begin
          if (cmp_hit_i) begin
            state_d = S_COPY_RD;
          end else if (idx_q == '0) begin
            state_d = S_DONE;
          end else begin
            idx_d   = idx_q - 1'b1;
            state_d = S_RD;
          end
        end
      end
      S_COPY_RD: begin
        state_d = S_COPY_WR;
      end
      S_COPY_WR: begin
        cnt_d     = cnt_q - 1'b1;
        removed_d = removed_q + 1'b1;
        if (idx_q == '0) begin
          state_d = S_DONE;
        end else begin
          idx_d   = idx_q - 1'b1;
          state_d = S_RD;
        end
      end
      S_WR: begin
        slot_d  = idx_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d         = 1'b1;
          out_d.entry_count   = nta_pkg::OUT_CNT_W'(cnt_q);
          out_d.slot          = nta_pkg::OUT_CNT_W'(slot_q);
          out_d.matched       = matched_q;
          out_d.dropped       = dropped_q;
          out_d.removed_count = nta_pkg::OUT_CNT_W'(removed_q);
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    idx_q     <= idx_d;
    removed_q <= removed_d;
    slot_q    <= slot_d;
    matched_q <= matched_d;
    dropped_q <= dropped_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q != S_IDLE))
    else $error("sequencer did not leave idle after an input transfer");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) && (!out_valid_q || out_ready_i) |=> out_valid_q)
    else $error("finished item did not load the result register");

  a_msg_removes_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) && (item_q.mode == nta_pkg::MODE_MSG) |-> (removed_q == '0))
    else $error("message item counted removed entries");

  a_count_drop_on_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q < $past(cnt_q)) |-> ($past(state_q) == S_COPY_WR))
    else $error("entry count fell outside a purge copy");

  a_match_not_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.matched && out_q.dropped))
    else $error("result both matched and dropped");

endmodule
